>>> src/median_then_moving_average_filter_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the filter core
// ---------------------------------------------------------------------------
`ifndef MEDIAN_THEN_MOVING_AVERAGE_FILTER_CORE_MACROS_SVH
`define MEDIAN_THEN_MOVING_AVERAGE_FILTER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define MTMA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtma: same-cycle check failed");

// next-cycle implication, disabled during reset
`define MTMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtma: next-cycle check failed");

`endif

>>> src/mtma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtma_pkg
// Shared data width and the unit status bundle for the median / average filter.
// ---------------------------------------------------------------------------
package mtma_pkg;

   localparam int unsigned DATA_W = 32;

   // status of an iterative unit
   typedef struct packed {
      logic busy;
      logic done;   // one-cycle pulse, result stable from here on
   } mtma_stat_type;

endpackage
`default_nettype wire

>>> src/median_then_moving_average_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// median_then_moving_average_filter_core
// Median filter followed by a moving average over distance samples.
// ---------------------------------------------------------------------------
// Each req beat carries one raw 32-bit distance; each rsp beat returns the
// median stage output and the averaged distance. One beat is in work at a
// time: req_ready is high only while the core is idle, and it stays high
// even while the previous rsp beat waits in the output register.
// Per beat, with M = MEDIAN_TAPS and A = AVERAGE_TAPS, the time taken is set
// by the rank sequencer in the median unit once the median window is full
// (M passes of M+1 rotations around one shared comparator) and by the
// restoring divider (one quotient bit per cycle while busy, over a dividend
// of W = 32 + clog2(A) bits, 35 at A = 8).
// Until M samples have arrived the raw sample passes through as the
// median; the average divides by the number of samples seen until A have
// arrived. Reset clears control state, counters and the running total only;
// window contents are not cleared.
module median_then_moving_average_filter_core
   import mtma_pkg::*;
#(
   parameter int unsigned MEDIAN_TAPS  = 5,
   parameter int unsigned AVERAGE_TAPS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [DATA_W-1:0] req_distance_sample,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [DATA_W-1:0]      rsp_median_value,
   output logic [DATA_W-1:0]      rsp_averaged_distance
);

`include "median_then_moving_average_filter_core_macros.svh"

   // running total never exceeds AVERAGE_TAPS * (2^32 - 1)
   localparam int unsigned TW  = DATA_W + $clog2(AVERAGE_TAPS);
   localparam int unsigned AFW = $clog2(AVERAGE_TAPS + 1);
   localparam int unsigned AW  = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
   localparam logic [AFW-1:0] AFULL_C = AFW'(AVERAGE_TAPS);
   localparam logic [AW-1:0]  ALAST_C = AW'(AVERAGE_TAPS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MEDIAN,
      S_ADD,
      S_LAUNCH,
      S_DIVIDE,
      S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [TW-1:0]     total_ff, total_in;
   logic [AFW-1:0]    afill_ff, afill_in;
   logic [AW-1:0]     aptr_ff, aptr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_med_ff, rsp_med_in;
   logic [DATA_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [DATA_W-1:0] oldest_ff;
   logic [DATA_W-1:0] avg_mem_ff [AVERAGE_TAPS];
   logic              mem_we;
   logic              med_start;
   logic              div_start;
   logic [DATA_W-1:0] med_value;
   logic [TW-1:0]     div_quotient;
   mtma_stat_type     med_stat;
   mtma_stat_type     div_stat;

   assign req_ready = (state_ff == S_IDLE);
   assign med_start = req_valid && req_ready;

   mtma_median #(
      .TAPS (MEDIAN_TAPS)
   ) u_median (
      .clock        (clock),
      .reset        (reset),
      .start        (med_start),
      .sample       (req_distance_sample),
      .median_value (med_value),
      .stat         (med_stat)
   );

   mtma_div #(
      .DW (TW),
      .VW (AFW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (afill_ff),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // average window: one write port, registered read of the slot about to be
   // overwritten (pointer moves only at a write, so it is stable before the next)
   always_ff @(posedge clock) begin
      if (mem_we) begin
         avg_mem_ff[aptr_ff] <= med_value;
      end
      oldest_ff <= avg_mem_ff[aptr_ff];
   end

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      afill_in     = afill_ff;
      aptr_in      = aptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_med_in   = rsp_med_ff;
      rsp_avg_in   = rsp_avg_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_MEDIAN;
            end
         end
         S_MEDIAN: begin
            if (med_stat.done) begin
               mem_we  = 1'b1;
               aptr_in = (aptr_ff == ALAST_C) ? '0 : aptr_ff + AW'(1);
               if (afill_ff < AFULL_C) begin
                  afill_in = afill_ff + AFW'(1);
               end else begin
                  // window full: retire the oldest sample first
                  total_in = total_ff - TW'(oldest_ff);
               end
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            total_in = total_ff + TW'(med_value);
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            div_start = 1'b1;
            state_in  = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (div_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_med_in   = med_value;
               rsp_avg_in   = div_quotient[DATA_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_med_ff <= rsp_med_in;
      rsp_avg_ff <= rsp_avg_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         afill_ff     <= '0;
         aptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         afill_ff     <= afill_in;
         aptr_ff      <= aptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_median_value      = rsp_med_ff;
   assign rsp_averaged_distance = rsp_avg_ff;

   // an accepted beat closes the input side until its result is formed
   `MTMA_ASSERT_NEXT(a_busy_after_accept, clock, reset, med_start, !req_ready)
   // the divider never sees an empty average window
   `MTMA_ASSERT_NOW(a_div_nonzero, clock, reset, div_start, afill_ff != '0)
   // median unit reports only while the sequencer waits for it
   `MTMA_ASSERT_NOW(a_med_done_state, clock, reset, med_stat.done, state_ff == S_MEDIAN)
   // the two iterative units never run at once
   `MTMA_ASSERT_NOW(a_units_exclusive, clock, reset, div_stat.busy, !med_stat.busy)

endmodule
`default_nettype wire

>>> src/mtma_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtma_median
// Window shift line plus a rank sequencer around one shared comparator.
// ---------------------------------------------------------------------------
module mtma_median
   import mtma_pkg::*;
#(
   parameter int unsigned TAPS = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] sample,
   output logic [DATA_W-1:0]      median_value,
   output mtma_stat_type          stat
);

   localparam int unsigned FW = $clog2(TAPS + 1);
   localparam int unsigned PW = $clog2(TAPS);
   localparam logic [FW-1:0] TAPS_C = FW'(TAPS);
   localparam logic [FW-1:0] LAST_C = FW'(TAPS - 1);
   localparam logic [FW-1:0] K_C    = FW'(TAPS / 2);
   localparam logic [PW-1:0] PLAST_C = PW'(TAPS - 1);

   logic [DATA_W-1:0] tap_ff [TAPS];
   logic [DATA_W-1:0] tap_in [TAPS];
   logic [DATA_W-1:0] cand_ff, cand_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [FW-1:0]     step_ff, step_in;
   logic [FW-1:0]     lt_ff, lt_in;
   logic [FW-1:0]     le_ff, le_in;
   logic [PW-1:0]     pass_ff, pass_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              cmp_lt, cmp_le;

   // the shared comparator
   assign cmp_lt = tap_ff[0] < cand_ff;
   assign cmp_le = tap_ff[0] <= cand_ff;

   always_comb begin
      tap_in    = tap_ff;
      cand_in   = cand_ff;
      result_in = result_ff;
      fill_in   = fill_ff;
      step_in   = step_ff;
      lt_in     = lt_ff;
      le_in     = le_ff;
      pass_in   = pass_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         // shift new sample in, oldest drops off the far end
         for (int i = 1; i < TAPS; i++) begin
            tap_in[i] = tap_ff[i-1];
         end
         tap_in[0] = sample;
         if (fill_ff < TAPS_C) begin
            fill_in = fill_ff + FW'(1);
         end
         if (fill_ff < LAST_C) begin
            result_in = sample;
            done_in   = 1'b1;
         end else begin
            busy_in = 1'b1;
            pass_in = '0;
            step_in = '0;
         end
      end else if (busy_ff) begin
         // rotate every step; TAPS+1 rotations per pass, TAPS passes in all
         for (int i = 1; i < TAPS; i++) begin
            tap_in[i] = tap_ff[i-1];
         end
         tap_in[0] = tap_ff[TAPS-1];
         step_in   = step_ff + FW'(1);
         if (step_ff == '0) begin
            cand_in = tap_ff[0];
            lt_in   = '0;
            le_in   = FW'(1);
         end else if (step_ff != TAPS_C) begin
            lt_in = lt_ff + FW'(cmp_lt);
            le_in = le_ff + FW'(cmp_le);
         end else begin
            step_in = '0;
            if (lt_ff <= K_C && le_ff > K_C) begin
               result_in = cand_ff;
            end
            if (pass_ff == PLAST_C) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               pass_in = pass_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      tap_ff    <= tap_in;
      cand_ff   <= cand_in;
      result_ff <= result_in;
      step_ff   <= step_in;
      lt_ff     <= lt_in;
      le_ff     <= le_in;
      pass_ff   <= pass_in;
      if (reset) begin
         fill_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign median_value = result_ff;
   assign stat.busy    = busy_ff;
   assign stat.done    = done_ff;

endmodule
`default_nettype wire

>>> src/mtma_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mtma_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mtma_div
   import mtma_pkg::*;
#(
   parameter int unsigned DW = 35,
   parameter int unsigned VW = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic [DW-1:0]      quotient,
   output mtma_stat_type      stat
);

   localparam int unsigned CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW:0]   rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;

   // shift in next dividend bit; remainder stays below divisor so VW+1 bits hold it
   assign trial = {rem_ff[VW-1:0], quo_ff[DW-1]};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
`default_nettype wire
